@@ rtl/object_def_model_ref_scanner_top_defines.svh @@
// assertion macros for the object definition model reference scanner
// expects clk and arst_n in the scope where the macros are used
`ifndef OBJECT_DEF_MODEL_REF_SCANNER_TOP_DEFINES_SVH
`define OBJECT_DEF_MODEL_REF_SCANNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ODMRS_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");
`define ODMRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");
`else
`define ODMRS_ASSERT_IMPLIES(lbl, ante, cons)
`define ODMRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/odmrs_pkg.sv @@
// shared types, codes and opcode classification for the scanner
// no dependencies
`timescale 1ns / 1ps
package odmrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_ENDIAN = 2'd2;

	localparam logic [31:0] TARGET_RST = 32'd0;
	localparam logic [7:0]  LIMIT_RST  = 8'd3;
	localparam logic        ENDIAN_RST = 1'b1;

	localparam logic [7:0] OP_MODEL16T = 8'd1;
	localparam logic [7:0] OP_MODEL16  = 8'd5;
	localparam logic [7:0] OP_MODEL32T = 8'd6;
	localparam logic [7:0] OP_MODEL32  = 8'd7;
	localparam logic [7:0] COUNT_MAX   = 8'd255;

	typedef enum logic [3:0] {
		MODE_OP,
		MODE_COUNT,
		MODE_ID,
		MODE_TYPE,
		MODE_ZTERM,
		MODE_SKIP,
		MODE_PRESKIP,
		MODE_CNT4,
		MODE_CNT2,
		MODE_STOP
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] skip;
	} cls_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_of_def;
		logic        last_of_def;
		logic [15:0] def_id;
		cls_t        cls;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// what the byte would start if it were read as an opcode
	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		c.mode = MODE_STOP;
		c.skip = 3'd0;
		case (b) inside
			OP_MODEL16T, OP_MODEL16, OP_MODEL32T, OP_MODEL32: c.mode = MODE_COUNT;
			8'd2, [8'd30:8'd34]: c.mode = MODE_ZTERM;
			8'd14, 8'd15, 8'd19, 8'd21, 8'd28, 8'd39, 8'd69, 8'd75: begin
				c.mode = MODE_SKIP;
				c.skip = 3'd1;
			end
			8'd24, 8'd29, 8'd61, [8'd65:8'd68], [8'd70:8'd72]: begin
				c.mode = MODE_SKIP;
				c.skip = 3'd2;
			end
			8'd40, 8'd41: c.mode = MODE_CNT4;
			8'd77: begin
				c.mode = MODE_PRESKIP;
				c.skip = 3'd4;
			end
			8'd92: begin
				c.mode = MODE_PRESKIP;
				c.skip = 3'd6;
			end
			default: c.mode = MODE_STOP;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/odmrs_front.sv @@
// front end: accepts definition bytes, classifies them and pushes them into the queue
// depends on odmrs_pkg
`timescale 1ns / 1ps
module odmrs_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 first_of_def,
	input  logic                 last_of_def,
	input  logic [15:0]          def_id,
	input  odmrs_pkg::q_stat_t   q_stat,
	output logic                 push,
	output odmrs_pkg::item_t     push_item
);

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.data_byte    = data_byte;
		push_item.first_of_def = first_of_def;
		push_item.last_of_def  = last_of_def;
		push_item.def_id       = def_id;
		push_item.cls          = odmrs_pkg::classify(data_byte);
	end

endmodule

@@ rtl/odmrs_queue.sv @@
// short queue of classified bytes between front and back end
// depends on odmrs_pkg
`timescale 1ns / 1ps
module odmrs_queue #(
	parameter int DEPTH = odmrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  odmrs_pkg::item_t   push_item,
	input  logic               pop,
	output odmrs_pkg::item_t   head,
	output odmrs_pkg::q_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	odmrs_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/odmrs_back.sv @@
// back end: opcode walk, id assembly, match reporting and output register
// depends on odmrs_pkg
`timescale 1ns / 1ps
module odmrs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        target_id,
	input  logic [7:0]         report_limit,
	input  logic               big_endian,
	input  odmrs_pkg::item_t   head,
	input  odmrs_pkg::q_stat_t q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        object_id,
	output logic [31:0]        model_id,
	output logic [7:0]         model_type,
	output logic               has_type,
	output logic [7:0]         list_opcode,
	output logic [7:0]         report_count
);

	odmrs_pkg::mode_t mode_q, n_mode, e_mode;
	logic [7:0]  opcode_q, n_opcode, e_opcode;
	logic [7:0]  entries_q, n_entries, e_entries, ent_dec;
	logic [10:0] skip_q, n_skip, e_skip, skip_dec;
	logic [2:0]  idx_q, n_idx, e_idx, idx_inc;
	logic [31:0] acc_q, n_acc, e_acc, acc_shift;
	logic [7:0]  found_q, n_found;
	logic        active_q, n_active, act;
	logic        typed, short_id, id_done;
	logic        hit;
	logic [31:0] rpt_id;
	logic [7:0]  rpt_type;
	logic [7:0]  b;

	assign pop = !q_stat.empty && (!out_valid || out_ready);
	assign b   = head.data_byte;

	// first byte of a definition clears the parse state before it is used
	always_comb begin
		e_mode    = head.first_of_def ? odmrs_pkg::MODE_OP : mode_q;
		e_opcode  = head.first_of_def ? 8'd0 : opcode_q;
		e_entries = head.first_of_def ? 8'd0 : entries_q;
		e_skip    = head.first_of_def ? 11'd0 : skip_q;
		e_idx     = head.first_of_def ? 3'd0 : idx_q;
		e_acc     = head.first_of_def ? 32'd0 : acc_q;
		act       = head.first_of_def ?
			((found_q < report_limit) && !head.last_of_def) : active_q;
		typed     = (e_opcode == odmrs_pkg::OP_MODEL16T) ||
			(e_opcode == odmrs_pkg::OP_MODEL32T);
		short_id  = (e_opcode == odmrs_pkg::OP_MODEL16T) ||
			(e_opcode == odmrs_pkg::OP_MODEL16);
		acc_shift = big_endian ? {e_acc[23:0], b} :
			(e_acc | ({24'd0, b} << {e_idx[1:0], 3'b000}));
		idx_inc   = e_idx + 3'd1;
		id_done   = short_id ? (idx_inc >= 3'd2) : (idx_inc >= 3'd4);
		ent_dec   = e_entries - 8'd1;
		skip_dec  = (e_skip != 11'd0) ? e_skip - 11'd1 : e_skip;
	end

	// next parse state
	always_comb begin
		n_mode    = e_mode;
		n_opcode  = e_opcode;
		n_entries = e_entries;
		n_skip    = e_skip;
		n_idx     = e_idx;
		n_acc     = e_acc;
		n_active  = act;
		if (act) begin
			case (e_mode)
				odmrs_pkg::MODE_OP: begin
					n_opcode = b;
					n_mode   = head.cls.mode;
					if (head.cls.skip != 3'd0) begin
						n_skip = {8'd0, head.cls.skip};
					end
				end
				odmrs_pkg::MODE_COUNT: begin
					n_entries = b;
					n_idx     = 3'd0;
					n_acc     = 32'd0;
					n_mode    = (b == 8'd0) ? odmrs_pkg::MODE_OP : odmrs_pkg::MODE_ID;
				end
				odmrs_pkg::MODE_ID: begin
					n_acc = acc_shift;
					n_idx = idx_inc;
					if (id_done) begin
						if (typed) begin
							n_mode = odmrs_pkg::MODE_TYPE;
						end else begin
							n_entries = ent_dec;
							n_idx     = 3'd0;
							n_acc     = 32'd0;
							n_mode    = (ent_dec == 8'd0) ?
								odmrs_pkg::MODE_OP : odmrs_pkg::MODE_ID;
						end
					end
				end
				odmrs_pkg::MODE_TYPE: begin
					n_entries = ent_dec;
					n_idx     = 3'd0;
					n_acc     = 32'd0;
					n_mode    = (ent_dec == 8'd0) ? odmrs_pkg::MODE_OP : odmrs_pkg::MODE_ID;
				end
				odmrs_pkg::MODE_ZTERM: begin
					if (b == 8'd0) begin
						n_mode = odmrs_pkg::MODE_OP;
					end
				end
				odmrs_pkg::MODE_SKIP: begin
					n_skip = skip_dec;
					if (skip_dec == 11'd0) begin
						n_mode = odmrs_pkg::MODE_OP;
					end
				end
				odmrs_pkg::MODE_PRESKIP: begin
					n_skip = skip_dec;
					if (skip_dec == 11'd0) begin
						n_mode = odmrs_pkg::MODE_CNT2;
					end
				end
				odmrs_pkg::MODE_CNT4: begin
					n_skip = {1'b0, b, 2'b00};
					n_mode = (b == 8'd0) ? odmrs_pkg::MODE_OP : odmrs_pkg::MODE_SKIP;
				end
				odmrs_pkg::MODE_CNT2: begin
					n_skip = {2'b00, b, 1'b0} + 11'd2;
					n_mode = odmrs_pkg::MODE_SKIP;
				end
				default: begin
					n_mode = e_mode;
				end
			endcase
		end
		if (head.last_of_def) begin
			n_active = 1'b0;
			n_mode   = odmrs_pkg::MODE_OP;
		end
	end

	// report decision
	always_comb begin
		rpt_id   = (e_mode == odmrs_pkg::MODE_ID) ? acc_shift : e_acc;
		rpt_type = (e_mode == odmrs_pkg::MODE_TYPE) ? b : 8'd0;
		hit      = act && (rpt_id == target_id) &&
			(((e_mode == odmrs_pkg::MODE_ID) && id_done && !typed) ||
			(e_mode == odmrs_pkg::MODE_TYPE));
		n_found  = found_q;
		if (hit && (found_q != odmrs_pkg::COUNT_MAX)) begin
			n_found = found_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= odmrs_pkg::MODE_OP;
			opcode_q  <= '0;
			entries_q <= '0;
			skip_q    <= '0;
			idx_q     <= '0;
			acc_q     <= '0;
			found_q   <= '0;
			active_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				mode_q    <= n_mode;
				opcode_q  <= n_opcode;
				entries_q <= n_entries;
				skip_q    <= n_skip;
				idx_q     <= n_idx;
				acc_q     <= n_acc;
				found_q   <= n_found;
				active_q  <= n_active;
			end
			if (pop && hit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hit) begin
			object_id    <= head.def_id;
			model_id     <= rpt_id;
			model_type   <= rpt_type;
			has_type     <= (e_mode == odmrs_pkg::MODE_TYPE);
			list_opcode  <= e_opcode;
			report_count <= n_found;
		end
	end

endmodule

@@ rtl/object_def_model_ref_scanner_top.sv @@
// top level of the object definition model reference scanner
// depends on odmrs_pkg, odmrs_front, odmrs_queue, odmrs_back and the defines header
//
// usage:
//   input channel (in_valid/in_ready) carries one byte of an object definition per
//   transfer, with first_of_def and last_of_def framing and the definition's def_id.
//   output channel (out_valid/out_ready) carries one report per model id in a model
//   list that equals the target id, in definitions that start while the count is below report_limit.
//   registers on the apb port: 0x0 target id, 0x4 report_limit, 0x8 big_endian;
//   write them only while no bytes are in flight.
// timing:
//   one byte per cycle sustained while out_ready takes each report; the opcode walk in
//   the back end then handles one byte per cycle from the queue. a report is registered
//   once the back end pops the byte that completes the match from the queue.
// stalls and reset:
//   while out_ready is low a pending report holds in the output register; the back
//   end stops and the queue (QUEUE_DEPTH bytes) absorbs input until in_ready drops.
//   reset empties the queue, drops any report and clears the parse state and count;
//   registers return to target 0, limit 3, big endian.
`timescale 1ns / 1ps
`include "object_def_model_ref_scanner_top_defines.svh"
module object_def_model_ref_scanner_top #(
	parameter int QUEUE_DEPTH = odmrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_of_def,
	input  logic        last_of_def,
	input  logic [15:0] def_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] object_id,
	output logic [31:0] model_id,
	output logic [7:0]  model_type,
	output logic        has_type,
	output logic [7:0]  list_opcode,
	output logic [7:0]  report_count
);

	logic [31:0] target_q;
	logic [7:0]  limit_q;
	logic        endian_q;
	logic        wr_en;

	odmrs_pkg::q_stat_t q_stat;
	odmrs_pkg::item_t   push_item, head;
	logic               push, pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= odmrs_pkg::TARGET_RST;
			limit_q  <= odmrs_pkg::LIMIT_RST;
			endian_q <= odmrs_pkg::ENDIAN_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				odmrs_pkg::REG_TARGET: target_q <= pwdata;
				odmrs_pkg::REG_LIMIT:  limit_q  <= pwdata[7:0];
				odmrs_pkg::REG_ENDIAN: endian_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			odmrs_pkg::REG_TARGET: prdata = target_q;
			odmrs_pkg::REG_LIMIT:  prdata = {24'd0, limit_q};
			odmrs_pkg::REG_ENDIAN: prdata = {31'd0, endian_q};
			default:               prdata = 32'd0;
		endcase
	end

	odmrs_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_of_def (first_of_def),
		.last_of_def  (last_of_def),
		.def_id       (def_id),
		.q_stat       (q_stat),
		.push         (push),
		.push_item    (push_item)
	);

	odmrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	odmrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_id    (target_q),
		.report_limit (limit_q),
		.big_endian   (endian_q),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.object_id    (object_id),
		.model_id     (model_id),
		.model_type   (model_type),
		.has_type     (has_type),
		.list_opcode  (list_opcode),
		.report_count (report_count)
	);

	// a report always counts itself
	`ODMRS_ASSERT_IMPLIES(a_count_nonzero, out_valid, report_count != 8'd0)
	// a byte pushed into an empty queue leaves it non-empty in the next cycle
	`ODMRS_ASSERT_NEXT(a_push_lands, push && q_stat.empty, !q_stat.empty)
	// back end never drains an empty queue
	`ODMRS_ASSERT_IMPLIES(a_no_pop_empty, q_stat.empty, !pop)

endmodule

@@ verif/odmrs_tb_pkg.sv @@
`timescale 1ns / 1ps
// opcode values the scanner testbench uses beyond the list opcodes of odmrs_pkg
// shared by the report checker and tb_top, no dependencies
package odmrs_tb_pkg;

	localparam logic [7:0] OP_END        = 8'd0;
	localparam logic [7:0] OP_STRING     = 8'd2;
	localparam logic [7:0] OP_UNKNOWN    = 8'd3;
	localparam logic [7:0] OP_TEXT_FIRST = 8'd30;
	localparam logic [7:0] OP_TEXT_LAST  = 8'd34;
	localparam logic [7:0] OP_CNT4_A     = 8'd40;
	localparam logic [7:0] OP_CNT4_B     = 8'd41;
	localparam logic [7:0] OP_PRESKIP4   = 8'd77;
	localparam logic [7:0] OP_PRESKIP6   = 8'd92;

	localparam int SKIP1_COUNT = 8;
	localparam logic [8*SKIP1_COUNT-1:0] SKIP1_OPS =
		{8'd14, 8'd15, 8'd19, 8'd21, 8'd28, 8'd39, 8'd69, 8'd75};
	localparam int SKIP2_COUNT = 10;
	localparam logic [8*SKIP2_COUNT-1:0] SKIP2_OPS =
		{8'd24, 8'd29, 8'd61, 8'd65, 8'd66, 8'd67, 8'd68, 8'd70, 8'd71, 8'd72};

endpackage

@@ verif/odmrs_report_checker.sv @@
`timescale 1ns / 1ps
// report checker: follows register writes and byte transfers, walks the opcode stream
// itself and compares each report of the scanner; needs odmrs_pkg and odmrs_tb_pkg
module odmrs_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_of_def,
	input  logic        last_of_def,
	input  logic [15:0] def_id,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] object_id,
	input  logic [31:0] model_id,
	input  logic [7:0]  model_type,
	input  logic        has_type,
	input  logic [7:0]  list_opcode,
	input  logic [7:0]  report_count,
	output int          mismatches,
	output int          pending
);
	import odmrs_pkg::*;
	import odmrs_tb_pkg::*;

	typedef struct packed {
		logic [15:0] obj;
		logic [31:0] model;
		logic [7:0]  mtype;
		logic        typed;
		logic [7:0]  op;
		logic [7:0]  count;
	} match_t;

	logic [31:0] cfg_target;
	logic [7:0]  cfg_limit;
	logic        cfg_big;

	mode_t       scan_mode;
	logic [7:0]  cur_op;
	logic [7:0]  entries_left;
	logic [10:0] skip_left;
	logic [2:0]  id_idx;
	logic [31:0] id_acc;
	logic [7:0]  found;
	logic        in_def;

	match_t      pending_matches[$];
	match_t      want;

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		$display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// an id (and type byte for typed lists) is complete
	task automatic finish_entry(input logic [15:0] did, input logic [7:0] mtype,
			input logic typed);
		match_t m;
		if (id_acc == cfg_target) begin
			if (found != COUNT_MAX)
				found++;
			m.obj = did;
			m.model = id_acc;
			m.mtype = mtype;
			m.typed = typed;
			m.op = cur_op;
			m.count = found;
			pending_matches.push_back(m);
		end
		entries_left--;
		if (entries_left == 8'd0) begin
			scan_mode = MODE_OP;
		end else begin
			id_idx = 3'd0;
			id_acc = 32'd0;
			scan_mode = MODE_ID;
		end
	endtask

	task automatic walk_byte(input logic [7:0] b, input logic [15:0] did);
		logic       typed;
		logic [2:0] id_len;
		int         i;
		typed = (cur_op == OP_MODEL16T) || (cur_op == OP_MODEL32T);
		id_len = (cur_op == OP_MODEL16T || cur_op == OP_MODEL16) ? 3'd2 : 3'd4;
		case (scan_mode)
			MODE_OP: begin
				cur_op = b;
				scan_mode = MODE_STOP;
				if (b == OP_MODEL16T || b == OP_MODEL16 || b == OP_MODEL32T || b == OP_MODEL32) begin
					scan_mode = MODE_COUNT;
				end else if (b == OP_STRING || (b >= OP_TEXT_FIRST && b <= OP_TEXT_LAST)) begin
					scan_mode = MODE_ZTERM;
				end else if (b == OP_CNT4_A || b == OP_CNT4_B) begin
					scan_mode = MODE_CNT4;
				end else if (b == OP_PRESKIP4 || b == OP_PRESKIP6) begin
					skip_left = (b == OP_PRESKIP4) ? 11'd4 : 11'd6;
					scan_mode = MODE_PRESKIP;
				end else begin
					for (i = 0; i < SKIP1_COUNT; i++) begin
						if (b == SKIP1_OPS[8*i +: 8]) begin
							skip_left = 11'd1;
							scan_mode = MODE_SKIP;
						end
					end
					for (i = 0; i < SKIP2_COUNT; i++) begin
						if (b == SKIP2_OPS[8*i +: 8]) begin
							skip_left = 11'd2;
							scan_mode = MODE_SKIP;
						end
					end
				end
			end
			MODE_COUNT: begin
				entries_left = b;
				if (b == 8'd0) begin
					scan_mode = MODE_OP;
				end else begin
					id_idx = 3'd0;
					id_acc = 32'd0;
					scan_mode = MODE_ID;
				end
			end
			MODE_ID: begin
				if (cfg_big)
					id_acc = {id_acc[23:0], b};
				else
					id_acc = id_acc | ({24'd0, b} << (8 * id_idx[1:0]));
				id_idx = id_idx + 3'd1;
				if (id_idx >= id_len) begin
					if (typed)
						scan_mode = MODE_TYPE;
					else
						finish_entry(did, 8'd0, 1'b0);
				end
			end
			MODE_TYPE: finish_entry(did, b, 1'b1);
			MODE_ZTERM: begin
				if (b == 8'd0)
					scan_mode = MODE_OP;
			end
			MODE_SKIP: begin
				if (skip_left != 11'd0)
					skip_left--;
				if (skip_left == 11'd0)
					scan_mode = MODE_OP;
			end
			MODE_PRESKIP: begin
				if (skip_left != 11'd0)
					skip_left--;
				if (skip_left == 11'd0)
					scan_mode = MODE_CNT2;
			end
			MODE_CNT4: begin
				skip_left = {1'b0, b, 2'b00};
				scan_mode = (b == 8'd0) ? MODE_OP : MODE_SKIP;
			end
			MODE_CNT2: begin
				skip_left = ({3'd0, b} + 11'd1) << 1;
				scan_mode = MODE_SKIP;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_target = TARGET_RST;
			cfg_limit = LIMIT_RST;
			cfg_big = ENDIAN_RST;
			scan_mode = MODE_OP;
			cur_op = 8'd0;
			entries_left = 8'd0;
			skip_left = 11'd0;
			id_idx = 3'd0;
			id_acc = 32'd0;
			found = 8'd0;
			in_def = 1'b0;
			pending_matches.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_TARGET: cfg_target = pwdata;
					REG_LIMIT:  cfg_limit = pwdata[7:0];
					REG_ENDIAN: cfg_big = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (first_of_def) begin
					scan_mode = MODE_OP;
					cur_op = 8'd0;
					entries_left = 8'd0;
					skip_left = 11'd0;
					id_idx = 3'd0;
					id_acc = 32'd0;
					in_def = (found < cfg_limit) && !last_of_def;
				end
				if (in_def)
					walk_byte(data_byte, def_id);
				if (last_of_def) begin
					in_def = 1'b0;
					scan_mode = MODE_OP;
				end
			end
			if (out_valid && out_ready) begin
				if (pending_matches.size() == 0) begin
					flag("unexpected report, model_id", model_id, 32'd0);
				end else begin
					want = pending_matches.pop_front();
					if (object_id !== want.obj)
						flag("object_id", 32'(object_id), 32'(want.obj));
					if (model_id !== want.model)
						flag("model_id", model_id, want.model);
					if (model_type !== want.mtype)
						flag("model_type", 32'(model_type), 32'(want.mtype));
					if (has_type !== want.typed)
						flag("has_type", 32'(has_type), 32'(want.typed));
					if (list_opcode !== want.op)
						flag("list_opcode", 32'(list_opcode), 32'(want.op));
					if (report_count !== want.count)
						flag("report_count", 32'(report_count), 32'(want.count));
				end
			end
			pending = pending_matches.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// top of the scanner testbench: clock, reset, register writes and definition byte stimulus
// needs odmrs_pkg, odmrs_tb_pkg, odmrs_report_checker and the scanner rtl
module tb_top;
	import odmrs_pkg::*;
	import odmrs_tb_pkg::*;

	localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH_DEF + 8;
	localparam int PHASE_BYTES = 440;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        first_of_def = 1'b0;
	logic        last_of_def = 1'b0;
	logic [15:0] def_id = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] object_id;
	logic [31:0] model_id;
	logic [7:0]  model_type;
	logic        has_type;
	logic [7:0]  list_opcode;
	logic [7:0]  report_count;

	int          mismatches;
	int          pending;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          bytes_sent = 0;
	logic [31:0] cur_target = TARGET_RST;
	logic        cur_big = ENDIAN_RST;
	logic [7:0]  def_bytes[$];

	object_def_model_ref_scanner_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.first_of_def(first_of_def), .last_of_def(last_of_def), .def_id(def_id),
		.out_valid(out_valid), .out_ready(out_ready), .object_id(object_id),
		.model_id(model_id), .model_type(model_type), .has_type(has_type),
		.list_opcode(list_opcode), .report_count(report_count)
	);

	odmrs_report_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.first_of_def(first_of_def), .last_of_def(last_of_def), .def_id(def_id),
		.out_valid(out_valid), .out_ready(out_ready), .object_id(object_id),
		.model_id(model_id), .model_type(model_type), .has_type(has_type),
		.list_opcode(list_opcode), .report_count(report_count),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// holds the input off until every report is out and the queue has emptied
	task automatic wait_drained;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic first, input logic last,
			input logic [15:0] did);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_of_def <= first;
		last_of_def <= last;
		def_id <= did;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_def(input logic [15:0] did, input bit close, input bit counted,
			input bit mix_ids);
		int          i;
		logic [15:0] byte_did;
		for (i = 0; i < def_bytes.size(); i++) begin
			byte_did = (mix_ids && $urandom_range(0, 9) == 0) ? 16'($urandom()) : did;
			push_byte(def_bytes[i], i == 0, close && i == def_bytes.size() - 1, byte_did);
		end
		if (counted)
			bytes_sent += def_bytes.size();
	endtask

	task automatic add_id(input logic [31:0] id, input bit wide);
		int n;
		int k;
		n = wide ? 4 : 2;
		for (k = 0; k < n; k++)
			def_bytes.push_back(cur_big ? id[8*(n-1-k) +: 8] : id[8*k +: 8]);
	endtask

	// a definition built from known opcodes, with ids often equal to the target
	task automatic gen_def;
		int          c;
		int          idx;
		logic [7:0]  op;
		logic [31:0] id;
		bit          wide;
		def_bytes.delete();
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					case ($urandom_range(0, 3))
						0: op = OP_MODEL16T;
						1: op = OP_MODEL16;
						2: op = OP_MODEL32T;
						default: op = OP_MODEL32;
					endcase
					wide = (op == OP_MODEL32T || op == OP_MODEL32);
					c = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
					def_bytes.push_back(op);
					def_bytes.push_back(8'(c));
					repeat (c) begin
						id = $urandom_range(0, 1) ? cur_target : $urandom();
						add_id(id, wide);
						if (op == OP_MODEL16T || op == OP_MODEL32T)
							def_bytes.push_back(8'($urandom()));
					end
				end
				4: begin
					op = $urandom_range(0, 1) ? OP_STRING
						: 8'($urandom_range(OP_TEXT_FIRST, OP_TEXT_LAST));
					def_bytes.push_back(op);
					repeat ($urandom_range(0, 5)) def_bytes.push_back(8'($urandom_range(1, 255)));
					def_bytes.push_back(8'd0);
				end
				5: begin
					idx = $urandom_range(0, SKIP1_COUNT - 1);
					def_bytes.push_back(SKIP1_OPS[8*idx +: 8]);
					def_bytes.push_back(8'($urandom()));
				end
				6: begin
					idx = $urandom_range(0, SKIP2_COUNT - 1);
					def_bytes.push_back(SKIP2_OPS[8*idx +: 8]);
					repeat (2) def_bytes.push_back(8'($urandom()));
				end
				7: begin
					def_bytes.push_back($urandom_range(0, 1) ? OP_CNT4_A : OP_CNT4_B);
					c = $urandom_range(0, 3);
					def_bytes.push_back(8'(c));
					repeat (4 * c) def_bytes.push_back(8'($urandom()));
				end
				8: begin
					op = $urandom_range(0, 1) ? OP_PRESKIP4 : OP_PRESKIP6;
					def_bytes.push_back(op);
					repeat ((op == OP_PRESKIP4) ? 4 : 6) def_bytes.push_back(8'($urandom()));
					c = $urandom_range(0, 2);
					def_bytes.push_back(8'(c));
					repeat (2 * (c + 1)) def_bytes.push_back(8'($urandom()));
				end
				default: ;
			endcase
		end
		// end of scan, with target ids behind it that must not be reported
		if ($urandom_range(0, 1)) begin
			def_bytes.push_back($urandom_range(0, 1) ? OP_END : OP_UNKNOWN);
			repeat ($urandom_range(0, 2)) begin
				def_bytes.push_back(OP_MODEL32);
				def_bytes.push_back(8'd1);
				add_id(cur_target, 1'b1);
			end
		end
		while (def_bytes.size() < 2) def_bytes.push_back(OP_END);
	endtask

	task automatic random_def;
		int          kind;
		int          keep;
		logic [15:0] did;
		kind = $urandom_range(0, 99);
		did = $urandom();
		if (kind < 80) begin
			gen_def();
			send_def(did, 1'b1, 1'b1, 1'b1);
		end else if (kind < 90) begin
			// cut short: closed early, or left open so the next first byte restarts
			gen_def();
			keep = $urandom_range(1, def_bytes.size());
			while (def_bytes.size() > keep) void'(def_bytes.pop_back());
			send_def(did, kind < 86, 1'b1, 1'b1);
		end else if (kind < 93) begin
			def_bytes.delete();
			def_bytes.push_back(8'($urandom()));
			send_def(did, 1'b1, 1'b0, 1'b0);
		end else if (kind < 97) begin
			def_bytes.delete();
			repeat ($urandom_range(1, 24)) def_bytes.push_back(8'($urandom()));
			send_def(did, 1'b1, 1'b1, 1'b1);
		end else begin
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom()), 1'b0, 1'b0, 16'($urandom()));
		end
	endtask

	initial begin
		int ph;
		int stop_at;
		bit paused;
		paused = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: target 0, limit 3, big endian
		push_byte(OP_MODEL16, 1'b0, 1'b0, 16'h1234);
		def_bytes = '{OP_MODEL16T};
		send_def(16'h0000, 1'b1, 1'b0, 1'b0);
		def_bytes = '{OP_MODEL32T, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_def(16'hFFFF, 1'b1, 1'b1, 1'b0);
		def_bytes = '{OP_MODEL32, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00};
		send_def(16'h0000, 1'b1, 1'b1, 1'b0);
		// second id cut off by the end of the definition
		def_bytes = '{OP_MODEL16, 8'd2, 8'h00, 8'h00, 8'h00};
		send_def(16'hA5C3, 1'b1, 1'b1, 1'b0);
		// limit reached, then limit zero and one: all ignored
		def_bytes = '{OP_MODEL16, 8'd1, 8'h00, 8'h00};
		wait_drained();
		reg_write(REG_LIMIT, 32'd0);
		send_def(16'h0001, 1'b1, 1'b1, 1'b0);
		wait_drained();
		reg_write(REG_LIMIT, 32'd1);
		send_def(16'h0002, 1'b1, 1'b1, 1'b0);

		for (ph = 0; ph < 3; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					tx_idle_pct = 28;
					rx_idle_pct = 84;
					cur_target = $urandom_range(0, 65535);
					cur_big = 1'b0;
				end
				1: begin
					tx_idle_pct = 84;
					rx_idle_pct = 28;
					cur_target = 32'hFFFF_FFFF;
					cur_big = 1'b1;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					cur_target = $urandom();
					cur_big = 1'b0;
				end
			endcase
			reg_write(REG_TARGET, cur_target);
			reg_write(REG_ENDIAN, {31'd0, cur_big});
			if (ph == 0)
				reg_write(REG_LIMIT, {24'd0, COUNT_MAX});
			stop_at = bytes_sent + PHASE_BYTES;
			while (bytes_sent < stop_at) begin
				if (!paused && bytes_sent >= stop_at - PHASE_BYTES / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				random_def();
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
